/* src/assert_macros.svh */
// Assertion macros used by the RTL top level of the ordered key/value table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset
`define OKVT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define OKVT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define OKVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/okvt_pkg.sv */
// Shared types and constants of the ordered key/value table
`default_nettype none

package okvt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 5;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int ENTRY_W  = KEY_W + VAL_W;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

endpackage

`default_nettype wire

/* src/ordered_key_value_table.sv */
// Ordered key/value table: top level with command sequencer and entry RAM
// One command is taken at a time and gives one result item. An add goes straight to
// the finish state, and its result enters the output register once the output is free.
// Search, update and remove compare one stored key per cycle against the command key,
// oldest first, and finish on the first hit or after the last stored entry. A remove
// that hits then moves every younger entry up one place at one entry per cycle. The
// scan and the shift are paced by the single read port of the entry RAM and the one
// key comparator. The next command can be taken in the cycle after its result is
// latched. The input is ready again once the result is latched, while that result may
// still wait at the output.
`default_nettype none
`include "assert_macros.svh"

module ordered_key_value_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_found_value,
    output logic [4:0]       o_occupancy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    localparam int IW = okvt_pkg::IDX_W;
    localparam int CW = okvt_pkg::CNT_W;

    t_state                       r_state;
    okvt_pkg::t_cmd               r_cmd;
    logic [okvt_pkg::KEY_W-1:0]   r_key;
    logic [okvt_pkg::VAL_W-1:0]   r_value;
    logic [IW-1:0]                r_idx;
    logic [CW-1:0]                r_count;
    okvt_pkg::t_status            r_status;
    logic [okvt_pkg::VAL_W-1:0]   r_found;

    logic                         w_accept;
    logic [CW-1:0]                w_next_idx;
    logic [CW-1:0]                w_next2_idx;
    logic                         w_full;
    logic                         w_hit;
    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    logic [okvt_pkg::ENTRY_W-1:0] w_wdata;
    logic [IW-1:0]                w_raddr;
    logic [okvt_pkg::ENTRY_W-1:0] w_rdata;
    logic [okvt_pkg::KEY_W-1:0]   w_rd_key;
    logic [okvt_pkg::VAL_W-1:0]   w_rd_value;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_next_idx  = CW'(r_idx) + CW'(1);
    assign w_next2_idx = CW'(r_idx) + CW'(2);
    assign w_full      = (r_count >= CW'(okvt_pkg::CAPACITY));
    assign w_rd_key    = w_rdata[okvt_pkg::ENTRY_W-1:okvt_pkg::VAL_W];
    assign w_rd_value  = w_rdata[okvt_pkg::VAL_W-1:0];
    assign w_hit       = (w_rd_key == r_key);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {r_key, r_value};
        w_raddr = '0;
        case (r_state)
            S_IDLE: begin
                w_we    = w_accept && (okvt_pkg::t_cmd'(i_cmd) == okvt_pkg::CMD_ADD) && !w_full;
                w_waddr = r_count[IW-1:0];
                w_wdata = {i_key, i_value};
            end
            S_SCAN: begin
                w_we    = w_hit && (r_cmd == okvt_pkg::CMD_UPDATE);
                w_raddr = w_next_idx[IW-1:0];
            end
            S_SHIFT: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                w_raddr = w_next2_idx[IW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    okvt_ram #(
        .WIDTH (okvt_pkg::ENTRY_W),
        .DEPTH (okvt_pkg::CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (r_state == S_FINISH && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= okvt_pkg::t_cmd'(i_cmd);
                        r_key   <= i_key;
                        r_value <= i_value;
                        r_idx   <= '0;
                        r_found <= '0;
                        if (okvt_pkg::t_cmd'(i_cmd) == okvt_pkg::CMD_ADD) begin
                            if (w_full) begin
                                r_status <= okvt_pkg::ST_FULL;
                            end else begin
                                r_status <= okvt_pkg::ST_DONE;
                                r_count  <= r_count + CW'(1);
                            end
                            r_state <= S_FINISH;
                        end else if (r_count == '0) begin
                            r_status <= okvt_pkg::ST_MISS;
                            r_state  <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_status <= okvt_pkg::ST_DONE;
                        if (r_cmd == okvt_pkg::CMD_SEARCH) begin
                            r_found <= w_rd_value;
                        end
                        if (r_cmd == okvt_pkg::CMD_REMOVE && w_next_idx < r_count) begin
                            r_state <= S_SHIFT;
                        end else begin
                            if (r_cmd == okvt_pkg::CMD_REMOVE) begin
                                r_count <= r_count - CW'(1);
                            end
                            r_state <= S_FINISH;
                        end
                    end else if (w_next_idx >= r_count) begin
                        r_status <= okvt_pkg::ST_MISS;
                        r_state  <= S_FINISH;
                    end else begin
                        r_idx <= w_next_idx[IW-1:0];
                    end
                end
                S_SHIFT: begin
                    r_idx <= w_next_idx[IW-1:0];
                    if (w_next2_idx >= r_count) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!o_valid || i_ready) begin
                        o_status      <= r_status;
                        o_found_value <= r_found;
                        o_occupancy   <= r_count;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `OKVT_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(okvt_pkg::CAPACITY), "entry count above capacity")
    `OKVT_ASSERT_NEXT(a_add_grows, w_accept && i_cmd == okvt_pkg::CMD_ADD && !w_full, r_count == $past(r_count) + CW'(1), "add did not grow table")
    `OKVT_ASSERT_SAME(a_full_occ, o_valid && o_status == okvt_pkg::ST_FULL, o_occupancy == CW'(okvt_pkg::CAPACITY), "full status below capacity")
    `OKVT_ASSERT_SAME(a_zero_found, o_valid && o_status != okvt_pkg::ST_DONE, o_found_value == '0, "found value on failed command")

endmodule

`default_nettype wire

/* src/okvt_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module okvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* tb/tb_ordered_key_value_table.sv */
// Self-checking testbench for the ordered key/value table: directed rows, random commands
module tb_ordered_key_value_table;
    timeunit 1ns;
    timeprecision 1ps;

    import okvt_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   found;
        logic [CNT_W-1:0]   occ;
    } t_outcome;

    typedef struct packed {
        t_cmd               cmd;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        int                 reps;
        bit                 typed;
        t_outcome           outcome;
    } t_row;

    localparam int N_ROWS = 24;
    localparam int PHASE_ITEMS = 500;

    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{CMD_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, '{ST_MISS, 32'h0, 5'd0}},
        '{CMD_UPDATE, 32'h0000_0000, 32'h1234_5678, 1, 1'b1, '{ST_MISS, 32'h0, 5'd0}},
        '{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 5'd0}},
        '{CMD_ADD,    32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b1, '{ST_DONE, 32'h0, 5'd1}},
        '{CMD_ADD,    32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b1, '{ST_DONE, 32'h0, 5'd2}},
        '{CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 5'd2}},
        '{CMD_SEARCH, 32'h8000_0000, 32'hAAAA_AAAA, 1, 1'b1,
          '{ST_DONE, 32'h7FFF_FFFF, 5'd2}},
        '{CMD_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1'b1,
          '{ST_DONE, 32'h8000_0000, 5'd2}},
        '{CMD_ADD,    32'h0000_0005, 32'h0000_0001, 1, 1'b0, '0},
        '{CMD_ADD,    32'h0000_0005, 32'h0000_0002, 1, 1'b0, '0},
        '{CMD_SEARCH, 32'h0000_0005, 32'h0000_0000, 1, 1'b0, '0},
        '{CMD_UPDATE, 32'h0000_0005, 32'hFFFF_FFFF, 1, 1'b0, '0},
        '{CMD_SEARCH, 32'h0000_0005, 32'h5555_5555, 1, 1'b0, '0},
        '{CMD_REMOVE, 32'h0000_0005, 32'h0000_0000, 1, 1'b0, '0},
        '{CMD_SEARCH, 32'h0000_0005, 32'h0000_0000, 1, 1'b0, '0},
        '{CMD_ADD,    32'h0000_0000, 32'h0000_0000, 13, 1'b0, '0},
        '{CMD_ADD,    32'h0000_0001, 32'h0000_0001, 1, 1'b1, '{ST_FULL, 32'h0, 5'd16}},
        '{CMD_UPDATE, 32'h0000_0000, 32'h5555_5555, 1, 1'b0, '0},
        '{CMD_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1'b0, '0},
        '{CMD_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, '0},
        '{CMD_REMOVE, 32'h8000_0000, 32'h0000_0000, 1, 1'b0, '0},
        '{CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0, '0},
        '{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0, '0},
        '{CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_cmd;
    logic [KEY_W-1:0]   i_key;
    logic [VAL_W-1:0]   i_value;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_status;
    logic [VAL_W-1:0]   o_found_value;
    logic [CNT_W-1:0]   o_occupancy;

    logic [KEY_W-1:0]   kv_keys [CAPACITY];
    logic [VAL_W-1:0]   kv_vals [CAPACITY];
    int                 kv_count;
    t_outcome           pending_results [$];
    int                 n_mismatch;
    int                 snd_idle_pct;
    int                 rcv_stall_pct;
    bit                 row_typed;
    t_outcome           row_outcome;
    logic [KEY_W-1:0]   key_pool [6];

    ordered_key_value_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_occupancy   (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_ordered_key_value_table: errors");
        $finish;
    end

    function automatic t_outcome table_apply(t_cmd c, logic [KEY_W-1:0] k,
                                             logic [VAL_W-1:0] v);
        t_outcome r;
        int hit;
        r = '{ST_DONE, '0, '0};
        hit = -1;
        if (c == CMD_ADD) begin
            if (kv_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                kv_keys[kv_count] = k;
                kv_vals[kv_count] = v;
                kv_count++;
            end
        end else begin
            for (int i = 0; i < kv_count; i++)
                if (hit < 0 && kv_keys[i] == k) hit = i;
            if (hit < 0) begin
                r.status = ST_MISS;
            end else begin
                case (c)
                    CMD_SEARCH: r.found = kv_vals[hit];
                    CMD_UPDATE: kv_vals[hit] = v;
                    default: begin
                        for (int j = hit; j + 1 < kv_count; j++) begin
                            kv_keys[j] = kv_keys[j + 1];
                            kv_vals[j] = kv_vals[j + 1];
                        end
                        kv_count--;
                    end
                endcase
            end
        end
        r.occ = CNT_W'(kv_count);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: result with nothing outstanding", $realtime);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("found_value", want.found, o_found_value);
                    check_field("occupancy", 32'(want.occ), 32'(o_occupancy));
                end
            end
            if (i_valid && o_ready) begin
                want = table_apply(t_cmd'(i_cmd), i_key, i_value);
                if (row_typed) want = row_outcome;
                pending_results.push_back(want);
            end
        end
    end

    always @(negedge i_clk)
        i_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);

    task automatic send_item(t_cmd c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                             bit typed, t_outcome outcome);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_valid     <= 1'b1;
        i_cmd       <= c;
        i_key       <= k;
        i_value     <= v;
        row_typed   = typed;
        row_outcome = outcome;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    initial begin
        int snd_phase [4];
        int rcv_phase [4];
        t_cmd c;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        int roll;
        bit fill;
        snd_phase = '{0, 50, 0, 23};
        rcv_phase = '{0, 0, 50, 23};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_key = '0;
        i_value = '0;
        i_ready = 1'b0;
        kv_count = 0;
        n_mismatch = 0;
        row_typed = 1'b0;
        row_outcome = '0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            for (int n = 0; n < DIR_ROWS[r].reps; n++)
                send_item(DIR_ROWS[r].cmd, DIR_ROWS[r].key, DIR_ROWS[r].value,
                          DIR_ROWS[r].typed, DIR_ROWS[r].outcome);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            snd_idle_pct  = snd_phase[p];
            rcv_stall_pct = rcv_phase[p];
            foreach (key_pool[i]) key_pool[i] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                fill = ((n / 48) % 2 == 0);
                roll = $urandom_range(0, 99);
                if (fill)
                    c = roll < 55 ? CMD_ADD : roll < 70 ? CMD_SEARCH :
                        roll < 85 ? CMD_UPDATE : CMD_REMOVE;
                else
                    c = roll < 15 ? CMD_ADD : roll < 40 ? CMD_SEARCH :
                        roll < 60 ? CMD_UPDATE : CMD_REMOVE;
                k = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, 5)] : $urandom;
                if ($urandom_range(0, 99) < 10) begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'h8000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end else begin
                    v = $urandom;
                end
                send_item(c, k, v, 1'b0, '0);
            end
            drain_results();
        end

        repeat (40) @(posedge i_clk);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("tb_ordered_key_value_table: clean");
        else
            $display("tb_ordered_key_value_table: errors");
        $finish;
    end

endmodule
